>>> rtl/row_budget_crossbar_read_core_assert.svh
// Assertion macros for the row-budget crossbar read core.
`ifndef ROW_BUDGET_CROSSBAR_READ_CORE_ASSERT_SVH
`define ROW_BUDGET_CROSSBAR_READ_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define RBCR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define RBCR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rbcr_pkg.sv
// Shared constants, types and table functions for the crossbar read core.
package rbcr_pkg;

  localparam int COLUMNS_DEF = 32;
  localparam int LEVELS      = 8;
  localparam int WEIGHT_W    = 32;
  localparam int CNT_W       = 7;
  localparam int ENTRY_W     = 7;
  localparam int TABLE_W     = ENTRY_W * (LEVELS + 1);
  localparam int RPR_W       = 7;
  localparam int COLUMN_W    = 5;
  localparam int COMP_W      = 4;
  localparam int BUDGET_MAX  = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int TDATA_IN_W  = 40;
  localparam int TDATA_OUT_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_PER_READ   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_TABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_TABLE     = 2'd2;

  // A read handed from the accumulator to the drain buffer.
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] active_rows;
  } close_ctl_t;

  function automatic logic [CNT_W-1:0] clamp_budget(input logic [RPR_W-1:0] rpr);
    logic [CNT_W-1:0] b;
    if (rpr == '0) begin
      b = CNT_W'(1);
    end else if (rpr > RPR_W'(BUDGET_MAX)) begin
      b = CNT_W'(BUDGET_MAX);
    end else begin
      b = CNT_W'(rpr);
    end
    return b;
  endfunction

  function automatic logic [ENTRY_W-1:0] tbl_entry(input logic [TABLE_W-1:0] tbl,
                                                   input int i);
    return tbl[ENTRY_W*i +: ENTRY_W];
  endfunction

  // First level whose threshold exceeds the clamped count, else the top level.
  function automatic logic [ENTRY_W-1:0] quantize(input logic [CNT_W-1:0]   count,
                                                  input logic [CNT_W-1:0]   bud,
                                                  input logic [TABLE_W-1:0] thr,
                                                  input logic [TABLE_W-1:0] lvl);
    logic [CNT_W-1:0]   x;
    logic [ENTRY_W-1:0] res;
    x   = (count < bud) ? count : bud;
    res = tbl_entry(lvl, LEVELS);
    for (int i = LEVELS; i >= 0; i--) begin
      if (x < tbl_entry(thr, i)) res = tbl_entry(lvl, i);
    end
    return res;
  endfunction

  function automatic logic [COMP_W-1:0] comparators(input logic [CNT_W-1:0]   rows,
                                                    input logic [TABLE_W-1:0] lvl);
    logic [COMP_W-1:0]  res;
    logic [CNT_W+1:0]   rows4;
    rows4 = {rows, 2'b00};
    res   = COMP_W'(LEVELS);
    for (int i = LEVELS; i >= 1; i--) begin
      if ((CNT_W+2)'(tbl_entry(lvl, i)) >= rows4) res = COMP_W'(i);
    end
    if (rows == '0) res = '0;
    return res;
  endfunction

endpackage

>>> rtl/rbcr_accum.sv
// Input register and per-column accumulator that closes reads on budget or last row.
module rbcr_accum #(
  parameter int COLUMNS = rbcr_pkg::COLUMNS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        s_tvalid,
  output logic                                        s_tready,
  input  logic [rbcr_pkg::TDATA_IN_W-1:0]             s_tdata,
  input  logic                                        s_tlast,
  input  logic [rbcr_pkg::CNT_W-1:0]                  budget,
  input  logic                                        snap_free,
  output rbcr_pkg::close_ctl_t                        close,
  output logic [COLUMNS-1:0][rbcr_pkg::CNT_W-1:0]     close_counts
);
  import rbcr_pkg::*;

  localparam int PAD_W = (COLUMNS > WEIGHT_W) ? COLUMNS : WEIGHT_W;

  logic                             in_valid;
  logic                             in_row;
  logic [WEIGHT_W-1:0]              in_weight;
  logic                             in_last;

  logic [COLUMNS-1:0][CNT_W-1:0]    counts;
  logic [COLUMNS-1:0][CNT_W-1:0]    counts_next;
  logic [CNT_W-1:0]                 active;
  logic [CNT_W-1:0]                 active_next;
  logic                             pending;
  logic                             pending_next;

  logic [PAD_W-1:0]                 wpad;
  logic [COLUMNS-1:0][CNT_W-1:0]    add_counts;
  logic [COLUMNS-1:0][CNT_W-1:0]    row_counts;
  logic [CNT_W-1:0]                 add_active;
  logic                             overflow;
  logic                             closes;
  logic                             process;
  logic                             transfer;

  always_comb begin
    // columns past the weight field see a zero weight bit
    wpad = PAD_W'(in_weight);
    for (int k = 0; k < COLUMNS; k++) begin
      add_counts[k] = counts[k] + CNT_W'(in_row & wpad[k]);
      row_counts[k] = CNT_W'(wpad[k]);
    end
    add_active = active + CNT_W'(in_row);
    overflow   = in_row && (active >= budget);
    closes     = overflow || in_last;
    process    = in_valid && !pending && (!closes || snap_free);
    transfer   = pending && snap_free;
    s_tready   = !in_valid || process;

    close.valid       = (process && closes) || transfer;
    close.active_rows = (pending || overflow) ? active : add_active;
    close_counts      = (pending || overflow) ? counts : add_counts;

    counts_next  = counts;
    active_next  = active;
    pending_next = pending;
    if (transfer) begin
      counts_next  = '0;
      active_next  = '0;
      pending_next = 1'b0;
    end else if (process) begin
      if (overflow) begin
        // overflowing row opens the next read; on the last row that read is held pending until the snapshot frees
        counts_next  = row_counts;
        active_next  = CNT_W'(1);
        pending_next = in_last;
      end else if (in_last) begin
        counts_next = '0;
        active_next = '0;
      end else begin
        counts_next = add_counts;
        active_next = add_active;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      counts   <= '0;
      active   <= '0;
      pending  <= 1'b0;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      counts  <= counts_next;
      active  <= active_next;
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_row    <= s_tdata[0];
      in_weight <= s_tdata[WEIGHT_W:1];
      in_last   <= s_tlast;
    end
  end

endmodule

>>> rtl/rbcr_drain.sv
// Snapshot of a closed read and the result register that drains it one column per cycle while m_tready allows.
module rbcr_drain #(
  parameter int COLUMNS = rbcr_pkg::COLUMNS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  rbcr_pkg::close_ctl_t                        close,
  input  logic [COLUMNS-1:0][rbcr_pkg::CNT_W-1:0]     close_counts,
  input  logic [rbcr_pkg::CNT_W-1:0]                  budget,
  input  logic [rbcr_pkg::TABLE_W-1:0]                threshold_table,
  input  logic [rbcr_pkg::TABLE_W-1:0]                level_table,
  output logic                                        snap_free,
  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  output logic [rbcr_pkg::TDATA_OUT_W-1:0]            m_tdata,
  output logic                                        m_tlast
);
  import rbcr_pkg::*;

  localparam int CIDX_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int CEXT_W  = (CIDX_W > COLUMN_W) ? CIDX_W : COLUMN_W;

  logic                             snap_valid;
  logic [CIDX_W-1:0]                snap_cnt;
  logic [COLUMNS-1:0][CNT_W-1:0]    snap_counts;
  logic [CNT_W-1:0]                 snap_active;

  logic                             out_load;
  logic                             emit;
  logic                             at_end;
  logic [CEXT_W-1:0]                col_ext;
  logic [TDATA_OUT_W-1:0]           out_word;

  always_comb begin
    out_load  = !m_tvalid || m_tready;
    emit      = snap_valid && out_load;
    at_end    = (snap_cnt == CIDX_W'(COLUMNS - 1));
    snap_free = !snap_valid || (at_end && emit);
    col_ext   = CEXT_W'(snap_cnt);
    out_word  = {1'b0,
                 comparators(snap_active, level_table),
                 snap_active,
                 quantize(snap_counts[0], budget, threshold_table, level_table),
                 col_ext[COLUMN_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
      snap_cnt   <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (close.valid) begin
        snap_valid <= 1'b1;
        snap_cnt   <= '0;
      end else if (emit) begin
        snap_cnt <= snap_cnt + 1'b1;
        if (at_end) snap_valid <= 1'b0;
      end
      if (out_load) m_tvalid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (close.valid) begin
      snap_counts <= close_counts;
      snap_active <= close.active_rows;
    end else if (emit) begin
      // advance: the next column moves to the head
      for (int k = 0; k < COLUMNS - 1; k++) begin
        snap_counts[k] <= snap_counts[k+1];
      end
    end
    if (emit) begin
      m_tdata <= out_word;
      m_tlast <= at_end;
    end
  end

endmodule

>>> rtl/row_budget_crossbar_read_core.sv
// Row-budget crossbar read core: top level with configuration registers.
// Takes one wordline per cycle (activation bit and one weight bit per column)
// and counts set weights of active rows per column. A read closes when the
// next active row would exceed rows_per_read clamped to 1..64, or on the
// wordline marked last; it then yields COLUMNS word results, one per cycle
// while m_tready holds, columns ascending, with tlast on the final column.
// A closed read is copied into a snapshot buffer and drained from there, so
// the next read keeps accumulating at one wordline per cycle; the input
// stalls only when another read closes before the snapshot has drained its
// COLUMNS results. An overflow on the last row closes two reads, and the
// second waits in the accumulator until the snapshot frees. A read's first
// result passes the input register, then the snapshot, then the result register.
// The user must write configuration through cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
module row_budget_crossbar_read_core #(
  parameter int COLUMNS = rbcr_pkg::COLUMNS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rbcr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rbcr_pkg::TABLE_W-1:0]       cfg_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [0] row_bit, [32:1] weight_bits, [39:33] zero
  input  logic [rbcr_pkg::TDATA_IN_W-1:0]    s_tdata,
  input  logic                               s_tlast,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [4:0] column, [11:5] level, [18:12] active_rows, [22:19] comparators_used, [23] zero
  output logic [rbcr_pkg::TDATA_OUT_W-1:0]   m_tdata,
  output logic                               m_tlast
);
  import rbcr_pkg::*;

  logic [RPR_W-1:0]                 rows_per_read;
  logic [TABLE_W-1:0]               threshold_table;
  logic [TABLE_W-1:0]               level_table;
  logic [CNT_W-1:0]                 budget;
  logic                             snap_free;
  close_ctl_t                       close_ctl;
  logic [COLUMNS-1:0][CNT_W-1:0]    close_counts;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_per_read   <= RPR_W'(8);
      threshold_table <= '0;
      level_table     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS_PER_READ:   rows_per_read   <= cfg_data[RPR_W-1:0];
        CFG_THRESHOLD_TABLE: threshold_table <= cfg_data;
        CFG_LEVEL_TABLE:     level_table     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign budget = clamp_budget(rows_per_read);

  rbcr_accum #(
    .COLUMNS (COLUMNS)
  ) u_accum (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tlast      (s_tlast),
    .budget       (budget),
    .snap_free    (snap_free),
    .close        (close_ctl),
    .close_counts (close_counts)
  );

  rbcr_drain #(
    .COLUMNS (COLUMNS)
  ) u_drain (
    .clk             (clk),
    .rst             (rst),
    .close           (close_ctl),
    .close_counts    (close_counts),
    .budget          (budget),
    .threshold_table (threshold_table),
    .level_table     (level_table),
    .snap_free       (snap_free),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tlast         (m_tlast)
  );

`include "row_budget_crossbar_read_core_assert.svh"

  `RBCR_ASSERT_IMP(a_load_free, close_ctl.valid, snap_free, "read closed into a busy snapshot")
  `RBCR_ASSERT_IMP(a_comp_zero, m_tvalid, ((m_tdata[22:19] == '0) == (m_tdata[18:12] == '0)), "comparator count disagrees with active rows")
  `RBCR_ASSERT_IMP(a_last_col, m_tvalid && m_tlast, m_tdata[4:0] == COLUMN_W'(COLUMNS - 1), "last result not on final column")
  `RBCR_ASSERT_NXT(a_col_step, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tdata[4:0] == COLUMN_W'($past(m_tdata[4:0]) + 1'b1)), "read drain skipped or stalled a column")

endmodule
